[hw/rtl/trial_division_primality_test_macros.svh]
// Assertion macros for the primality test RTL
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TDP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tdp_pkg.sv]
// Package: constants and shared types for the primality test
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int NUMBER_BITS_DEFAULT = 32;
  localparam int CAND_BITS           = 32;

  // Trial divisor sequence: 3, 5, 7, ...; 2 is the only even prime
  localparam int FIRST_DIVISOR   = 3;
  localparam int DIVISOR_STEP    = 2;
  localparam int ONLY_EVEN_PRIME = 2;
  localparam int FIRST_SQUARE    = FIRST_DIVISOR * FIRST_DIVISOR;

  // Status from the serial remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

[hw/rtl/trial_division_primality_test.sv]
// Top level: trial-division primality test with a bit-serial remainder unit
//
//   channel  signals                                   direction
//   -------  ----------------------------------------  ---------
//   input    in_valid, in_ready, candidate_value[31:0]  in
//   output   out_valid, out_ready, is_prime             out
//
// One item at a time. Values below 3 and even values skip the divisor loop
// and go straight to FINISH. Each odd trial divisor runs a bound check, VW
// remainder steps and the remainder result; VW is min(NUMBER_BITS, 32).
// Synchronous active-high reset clears control; the result register holds
// until taken, and a new item may be accepted while it waits.
`timescale 1ns / 1ps
`include "trial_division_primality_test_macros.svh"

module trial_division_primality_test #(
  parameter int NUMBER_BITS = tdp_pkg::NUMBER_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tdp_pkg::CAND_BITS-1:0] candidate_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_prime
);

  localparam int VW = (NUMBER_BITS < tdp_pkg::CAND_BITS) ? NUMBER_BITS : tdp_pkg::CAND_BITS;
  localparam int DW = (VW + 1) / 2 + 1;
  localparam int SW = VW + 2;

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    BOUND  = 4'b0010,
    DIVIDE = 4'b0100,
    FINISH = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [VW-1:0] n;
  logic [DW-1:0] d;
  logic [SW-1:0] sq;
  logic          prime;

  logic [VW-1:0] n_in;
  logic          in_take;
  logic          trivial;
  logic          rem_start;
  logic          result_load;
  tdp_pkg::rem_rsp_t rsp;

  assign n_in        = candidate_value[VW-1:0];
  assign in_ready    = (state == IDLE);
  assign in_take     = in_valid && in_ready;
  assign trivial     = (n_in < VW'(tdp_pkg::FIRST_DIVISOR)) || !n_in[0];
  assign rem_start   = (state == BOUND) && (sq <= SW'(n));
  assign result_load = (state == FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:   if (in_take) state_next = trivial ? FINISH : BOUND;
      BOUND:  state_next = rem_start ? DIVIDE : FINISH;
      DIVIDE: begin
        if (rsp.done) state_next = rsp.zero ? FINISH : BOUND;
      end
      FINISH: if (result_load) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      n     <= n_in;
      d     <= DW'(tdp_pkg::FIRST_DIVISOR);
      sq    <= SW'(tdp_pkg::FIRST_SQUARE);
      prime <= (n_in == VW'(tdp_pkg::ONLY_EVEN_PRIME));
    end else if ((state == BOUND) && !rem_start) begin
      prime <= 1'b1;
    end else if ((state == DIVIDE) && rsp.done) begin
      if (rsp.zero) begin
        prime <= 1'b0;
      end else begin
        // (d+2)^2 = d^2 + 4d + 4
        sq <= sq + SW'({d, 2'b00}) + SW'(4);
        d  <= d + DW'(tdp_pkg::DIVISOR_STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      is_prime <= prime;
    end
  end

  tdp_rem_unit #(
    .VW(VW),
    .DW(DW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (n),
    .divisor  (d),
    .rsp      (rsp)
  );

  `TDP_ASSERT_NOW(a_divisor_odd, clk, rst, state == BOUND, d[0], "trial divisor is even")
  `TDP_ASSERT_NOW(a_square_tracks, clk, rst, state == BOUND,
    sq == (SW'(d) * SW'(d)), "square register out of step with divisor")
  `TDP_ASSERT_NOW(a_done_in_divide, clk, rst, rsp.done, state == DIVIDE,
    "remainder result outside divide state")
  `TDP_ASSERT_NEXT(a_start_to_divide, clk, rst, rem_start, state == DIVIDE && !rsp.done,
    "divider start did not enter divide state")

endmodule

[hw/rtl/tdp_rem_unit.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle
`timescale 1ns / 1ps

module tdp_rem_unit #(
  parameter int VW = tdp_pkg::CAND_BITS,
  parameter int DW = (tdp_pkg::CAND_BITS + 1) / 2 + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VW-1:0]    dividend,
  input  logic [DW-1:0]    divisor,
  output tdp_pkg::rem_rsp_t rsp
);

  localparam int CW = $clog2(VW + 1);

  logic [VW-1:0] shreg;
  logic [DW-1:0] dreg;
  logic [DW-1:0] r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // Partial remainder stays below the divisor, so the shifted value is < 2*d
  assign trial = {r, shreg[VW-1]};
  assign diff  = trial - {1'b0, dreg};
  assign fits  = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dreg  <= divisor;
      r     <= '0;
    end else if (busy) begin
      shreg <= {shreg[VW-2:0], 1'b0};
      r     <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.zero = (r == '0);

endmodule
